/* rtl/core/bfa_pkg.sv */
// Shared constants for the bitmap frame allocator: defaults, request and status codes,
// and the layout of one frame entry in the state RAM.
// No dependencies.
package bfa_pkg;

  localparam int NUM_FRAMES_DEF  = 32768;
  localparam int FRAME_BYTES_DEF = 4096;  // power of two

  localparam logic [2:0] MODE_ALLOC     = 3'd0;
  localparam logic [2:0] MODE_FREE      = 3'd1;
  localparam logic [2:0] MODE_REF       = 3'd2;
  localparam logic [2:0] MODE_MARK_USED = 3'd3;
  localparam logic [2:0] MODE_MARK_FREE = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // one RAM word per frame: used bit over reference count
  typedef struct packed {
    logic       used;
    logic [7:0] refs;
  } entry_t;

  localparam int ENTRY_W = 9;

endpackage

/* rtl/core/bitmap_frame_allocator_refcount.sv */
// Page-frame allocator top level: request sequencer around one frame-state RAM.
// Depends on bfa_pkg and bfa_ram.
//
//  channel  | signals                                  | transfer
//  ---------+------------------------------------------+----------------------
//  request  | mode phys_addr length count              | start & !busy
//  result   | status result_addr ref_count free_frames | done, high for one cycle
//
// After reset a clearing pass marks every frame used; busy is high.
// Allocate: frames are scanned up to the end of the first free run of count frames, then
// the run is written. Free, reference, mark: each frame walked is read, then written
// back through the RAM write port if in range; at least one frame is walked unless rejected.
// One request at a time; results cannot be stalled.
module bitmap_frame_allocator_refcount #(
  parameter int NUM_FRAMES  = bfa_pkg::NUM_FRAMES_DEF,
  parameter int FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [31:0] phys_addr,
  input  logic [31:0] length,
  input  logic [15:0] count,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] result_addr,
  output logic [7:0]  ref_count,
  output logic [15:0] free_frames
);

  localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int TW = $clog2(NUM_FRAMES + 1);
  localparam int SH = $clog2(FRAME_BYTES);
  localparam int XW = 34;
  localparam logic [XW-1:0] NF_X = XW'(NUM_FRAMES);
  localparam logic [XW-1:0] FB1  = XW'(FRAME_BYTES - 1);
  localparam logic [AW-1:0] LAST_F = AW'(NUM_FRAMES - 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;

  logic [2:0]    state;
  logic [2:0]    mode_r;
  logic [15:0]   cnt_r;
  logic [XW-1:0] first_r, lim_r, cur;
  logic [AW-1:0] clr_f, fill_f, start_f, rf;
  logic [AW:0]   scan_f;
  logic [16:0]   run;
  logic [15:0]   fill_left;
  logic          rv;
  logic [TW-1:0] used_total;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  bfa_pkg::entry_t    ram_wdata, ram_q;
  logic [bfa_pkg::ENTRY_W-1:0] q_bits;

  bfa_ram #(.WIDTH(bfa_pkg::ENTRY_W), .DEPTH(NUM_FRAMES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (q_bits)
  );
  assign ram_q = q_bits;

  // request decode
  logic [XW-1:0] addr_x, end_x, fr_dn, fr_up, first_c, last_c, lim_c, cnt_x;
  always_comb begin
    addr_x = XW'(phys_addr);
    end_x  = addr_x + XW'(length);
    cnt_x  = XW'(count);
    fr_dn  = addr_x >> SH;
    fr_up  = (addr_x + FB1) >> SH;
    first_c = (mode == bfa_pkg::MODE_MARK_FREE) ? fr_up : fr_dn;
    case (mode)
      bfa_pkg::MODE_FREE:      last_c = fr_dn + cnt_x;
      bfa_pkg::MODE_REF:       last_c = fr_dn + XW'(1);
      bfa_pkg::MODE_MARK_USED: last_c = (end_x + FB1) >> SH;
      bfa_pkg::MODE_MARK_FREE: last_c = end_x >> SH;
      default:                 last_c = '0;
    endcase
    lim_c = (last_c < NF_X) ? last_c : NF_X;
  end

  // read-modify-write of one frame
  logic            active;
  bfa_pkg::entry_t upd;
  logic            tot_inc, tot_dec;
  always_comb begin
    active  = cur < lim_r;
    upd     = ram_q;
    tot_inc = 1'b0;
    tot_dec = 1'b0;
    case (mode_r)
      bfa_pkg::MODE_FREE: begin
        if (active && ram_q.used) begin
          if (ram_q.refs > 8'd1) begin
            upd.refs = ram_q.refs - 8'd1;
          end else begin
            upd.refs = 8'd0;
            upd.used = 1'b0;
            tot_dec  = 1'b1;
          end
        end
      end
      bfa_pkg::MODE_REF: begin
        if (active && ram_q.refs != 8'hFF) upd.refs = ram_q.refs + 8'd1;
      end
      bfa_pkg::MODE_MARK_USED: begin
        if (active && !ram_q.used) begin
          upd.used = 1'b1;
          tot_inc  = 1'b1;
        end
      end
      bfa_pkg::MODE_MARK_FREE: begin
        if (active && ram_q.used) begin
          upd.used = 1'b0;
          tot_dec  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // scan: run tracking on returned read data
  logic [16:0]   run_inc;
  logic          hit;
  logic [AW-1:0] run_start;
  always_comb begin
    run_inc   = run + 17'd1;
    run_start = (run == 17'd0) ? rf : start_f;
    hit       = rv && !ram_q.used && (run_inc == {1'b0, cnt_r});
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur[AW-1:0];
    ram_wdata = upd;
    ram_raddr = cur[AW-1:0];
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_f;
        ram_wdata = '{used: 1'b1, refs: 8'd0};
      end
      S_SCAN: ram_raddr = scan_f[AW-1:0];
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_f;
        ram_wdata = '{used: 1'b1, refs: 8'd1};
      end
      S_WR: ram_we = active;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  logic [31:0] free_w;
  assign free_w      = 32'(NUM_FRAMES) - 32'(used_total);
  assign free_frames = free_w[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_f      <= '0;
      used_total <= TW'(NUM_FRAMES);
      done       <= 1'b0;
      rv         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          clr_f <= clr_f + AW'(1);
          if (clr_f == LAST_F) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            mode_r      <= mode;
            cnt_r       <= count;
            first_r     <= first_c;
            cur         <= first_c;
            lim_r       <= lim_c;
            status      <= bfa_pkg::ST_OK;
            result_addr <= 32'd0;
            ref_count   <= 8'd0;
            run         <= '0;
            scan_f      <= '0;
            rv          <= 1'b0;
            case (mode)
              bfa_pkg::MODE_ALLOC: begin
                if (count == 16'd0 || cnt_x > NF_X) begin
                  status <= bfa_pkg::ST_NOSPACE;
                  done   <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              bfa_pkg::MODE_FREE: begin
                if (count == 16'd0) begin
                  status <= bfa_pkg::ST_NOSPACE;
                  done   <= 1'b1;
                end else if (first_c >= NF_X) begin
                  status <= bfa_pkg::ST_RANGE;
                  done   <= 1'b1;
                end else begin
                  state <= S_RD;
                end
              end
              bfa_pkg::MODE_REF, bfa_pkg::MODE_MARK_USED, bfa_pkg::MODE_MARK_FREE: begin
                if (first_c >= NF_X) begin
                  status <= bfa_pkg::ST_RANGE;
                  done   <= 1'b1;
                end else begin
                  state <= S_RD;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_SCAN: begin
          rv <= scan_f < (AW+1)'(NUM_FRAMES);
          rf <= scan_f[AW-1:0];
          if (scan_f < (AW+1)'(NUM_FRAMES)) scan_f <= scan_f + (AW+1)'(1);
          if (rv) begin
            if (ram_q.used) begin
              run <= '0;
            end else begin
              run     <= run_inc;
              start_f <= run_start;
            end
          end
          if (hit) begin
            fill_f      <= run_start;
            fill_left   <= cnt_r;
            result_addr <= 32'(XW'(run_start) << SH);
            state       <= S_FILL;
          end else if (rv && rf == LAST_F) begin
            status <= bfa_pkg::ST_NOSPACE;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_FILL: begin
          // run was all free: every write sets a used bit
          used_total <= used_total + TW'(1);
          fill_f     <= fill_f + AW'(1);
          fill_left  <= fill_left - 16'd1;
          if (fill_left == 16'd1) begin
            ref_count <= 8'd1;
            done      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (tot_inc) used_total <= used_total + TW'(1);
          if (tot_dec) used_total <= used_total - TW'(1);
          if (cur == first_r) ref_count <= upd.refs;
          cur <= cur + XW'(1);
          if (active && (cur + XW'(1) < lim_r)) begin
            state <= S_RD;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/bfa_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/bfa_checker.sv */
// Port-level checks for the frame allocator, bound to the top level.
// Depends on bfa_pkg and bitmap_frame_allocator_refcount.
module bfa_props (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [31:0] result_addr,
  input logic [7:0]  ref_count
);

  // results come only from the idle side of a finished request
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // a result follows either a transfer or a busy cycle
  a_cause: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy || start))
    else $error("result strobe without a request");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == bfa_pkg::ST_OK || status == bfa_pkg::ST_NOSPACE ||
              status == bfa_pkg::ST_RANGE))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != bfa_pkg::ST_OK) |-> (result_addr == 32'd0 && ref_count == 8'd0))
    else $error("failed request reports address or count");

  a_alloc_ref: assert property (@(posedge clk) disable iff (rst)
    (done && result_addr != 32'd0) |-> (ref_count == 8'd1))
    else $error("allocated run without count of one");

endmodule

bind bitmap_frame_allocator_refcount bfa_props u_bfa_props (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .result_addr (result_addr),
  .ref_count   (ref_count)
);
